// File: hdl/gbt_pkg.sv
// shared types, constants and helper functions of the gyro bias tracker
// no dependencies; imported by every module of the block
package gbt_pkg;

  localparam int ORIENTATIONS = 24;

  localparam int DW    = 24;          // sample width, Q8.16
  localparam int OW    = 5;           // orientation index width
  localparam int AW    = 24;          // alpha width, Q0.24
  localparam int CW    = 16;          // still counter width
  localparam int TW    = 48;          // threshold width, Q16.32
  localparam int BW    = 40;          // bias width, Q8.32
  localparam int IW    = 3;           // config index width
  localparam int GFRAC = 16;          // extra fraction bits of the bias over a sample
  localparam int PW    = 48;          // alpha times sample
  localparam int DSQ_W = 2 * DW + 1;  // squared accel change, one axis
  localparam int GSQ_W = 2 * DW - 1;  // squared gyro, one axis
  localparam int ASUM_W = 2 * DW + 2; // squared accel change norm
  localparam int GSUM_W = 2 * DW;     // squared gyro norm

  localparam logic [IW-1:0] REG_ORIENT      = 3'd0;
  localparam logic [IW-1:0] REG_LEARN_ALPHA = 3'd1;
  localparam logic [IW-1:0] REG_TRACK_ALPHA = 3'd2;
  localparam logic [IW-1:0] REG_LEARN_LIMIT = 3'd3;
  localparam logic [IW-1:0] REG_ACCEL_TH    = 3'd4;
  localparam logic [IW-1:0] REG_GYRO_TH     = 3'd5;

  // axis codes: {negate, source axis}
  localparam logic [2:0] AX_PX = 3'b000;
  localparam logic [2:0] AX_PY = 3'b001;
  localparam logic [2:0] AX_PZ = 3'b010;
  localparam logic [2:0] AX_NX = 3'b100;
  localparam logic [2:0] AX_NY = 3'b101;
  localparam logic [2:0] AX_NZ = 3'b110;

  localparam logic [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef logic [2:0][DW-1:0] vec3_t;
  typedef logic [2:0][PW-1:0] prod3_t;
  typedef logic [2:0][2:0]    axis_codes_t;

  typedef struct packed {
    logic [OW-1:0] orient;
    logic [AW-1:0] learn_alpha;
    logic [AW-1:0] track_alpha;
    logic [CW-1:0] learn_limit;
    logic [TW-1:0] accel_th;
    logic [TW-1:0] gyro_th;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    orient:      OW'(0),
    learn_alpha: AW'(335544),
    track_alpha: AW'(1678),
    learn_limit: CW'(500),
    accel_th:    TW'(10737418),
    gyro_th:     TW'(171798692)
  };

  // beat handed from the still detector to the bias stage
  typedef struct packed {
    logic   still;
    vec3_t  gyro;
    vec3_t  accel;
    prod3_t learn_prod;
    prod3_t track_prod;
  } stage_t;

  function automatic axis_codes_t pack3(input logic [2:0] cx, input logic [2:0] cy,
                                        input logic [2:0] cz);
    axis_codes_t m;
    m[0] = cx;
    m[1] = cy;
    m[2] = cz;
    return m;
  endfunction

  function automatic axis_codes_t orient_map(input logic [OW-1:0] sel);
    axis_codes_t m;
    m = pack3(AX_PX, AX_PY, AX_PZ);
    if (int'(sel) < ORIENTATIONS) begin
      case (sel)
        5'd1:  m = pack3(AX_NY, AX_PX, AX_PZ);
        5'd2:  m = pack3(AX_NX, AX_NY, AX_PZ);
        5'd3:  m = pack3(AX_PY, AX_NX, AX_PZ);
        5'd4:  m = pack3(AX_PX, AX_NY, AX_NZ);
        5'd5:  m = pack3(AX_PY, AX_PX, AX_NZ);
        5'd6:  m = pack3(AX_NX, AX_PY, AX_NZ);
        5'd7:  m = pack3(AX_NY, AX_NX, AX_NZ);
        5'd8:  m = pack3(AX_PY, AX_NZ, AX_NX);
        5'd9:  m = pack3(AX_PZ, AX_PY, AX_NX);
        5'd10: m = pack3(AX_NY, AX_PZ, AX_NX);
        5'd11: m = pack3(AX_NZ, AX_NY, AX_NX);
        5'd12: m = pack3(AX_PY, AX_PZ, AX_PX);
        5'd13: m = pack3(AX_NZ, AX_PY, AX_PX);
        5'd14: m = pack3(AX_NY, AX_NZ, AX_PX);
        5'd15: m = pack3(AX_PZ, AX_NY, AX_PX);
        5'd16: m = pack3(AX_PX, AX_PZ, AX_NY);
        5'd17: m = pack3(AX_NZ, AX_PX, AX_NY);
        5'd18: m = pack3(AX_NX, AX_NZ, AX_NY);
        5'd19: m = pack3(AX_PZ, AX_NX, AX_NY);
        5'd20: m = pack3(AX_PX, AX_NZ, AX_PY);
        5'd21: m = pack3(AX_PZ, AX_PX, AX_PY);
        5'd22: m = pack3(AX_NX, AX_PZ, AX_PY);
        5'd23: m = pack3(AX_NZ, AX_NX, AX_PY);
        default: m = pack3(AX_PX, AX_PY, AX_PZ);
      endcase
    end
    return m;
  endfunction

  // negation with the most negative value pinned to the maximum
  function automatic logic [DW-1:0] neg_sat(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    if (v == S_MIN) r = S_MAX;
    else r = ~v + 1'b1;
    return r;
  endfunction

  function automatic logic [DW-1:0] sat_one(input logic [DW:0] v);
    logic [DW-1:0] r;
    if (v[DW] != v[DW-1]) r = v[DW] ? S_MIN : S_MAX;
    else r = v[DW-1:0];
    return r;
  endfunction

endpackage

// File: hdl/gyro_bias_tracker_axis_remap_unit.sv
// Gyro zero-rate bias tracker with axis remap. Takes one gyro and accel sample
// (signed Q8.16) per beat and returns one result beat per sample: the remapped
// accel, the remapped gyro minus its Q8.32 bias estimate, a still flag and the
// bias-valid flag. A new sample is accepted every clock cycle unless the output
// stalls; each passes the input, remap, still, bias and result registers. The
// rate is set by the bias recurrence stage, which closes alpha times bias (two
// 24x20 partial products) and the bias add. Configuration is to be written by
// the user through wr_en/wr_index/wr_data while no sample is in flight; the
// block does not enforce this. Uses gbt_pkg, gbt_front, gbt_remap and gbt_bias.
module gyro_bias_tracker_axis_remap_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [gbt_pkg::IW-1:0]             wr_index,
  input  logic [gbt_pkg::TW-1:0]             wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [gbt_pkg::DW-1:0]      gyro_in_x,
  input  logic signed [gbt_pkg::DW-1:0]      gyro_in_y,
  input  logic signed [gbt_pkg::DW-1:0]      gyro_in_z,
  input  logic signed [gbt_pkg::DW-1:0]      accel_in_x,
  input  logic signed [gbt_pkg::DW-1:0]      accel_in_y,
  input  logic signed [gbt_pkg::DW-1:0]      accel_in_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [gbt_pkg::DW-1:0]      gyro_out_x,
  output logic signed [gbt_pkg::DW-1:0]      gyro_out_y,
  output logic signed [gbt_pkg::DW-1:0]      gyro_out_z,
  output logic signed [gbt_pkg::DW-1:0]      accel_out_x,
  output logic signed [gbt_pkg::DW-1:0]      accel_out_y,
  output logic signed [gbt_pkg::DW-1:0]      accel_out_z,
  output logic                               still_seen,
  output logic                               bias_valid
);
  import gbt_pkg::*;

  cfg_t   cfg;
  vec3_t  gyro_raw, accel_raw;
  vec3_t  gyro_res, accel_res;
  logic   mid_valid, mid_ready;
  stage_t mid_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_ORIENT:      cfg.orient      <= wr_data[OW-1:0];
        REG_LEARN_ALPHA: cfg.learn_alpha <= wr_data[AW-1:0];
        REG_TRACK_ALPHA: cfg.track_alpha <= wr_data[AW-1:0];
        REG_LEARN_LIMIT: cfg.learn_limit <= wr_data[CW-1:0];
        REG_ACCEL_TH:    cfg.accel_th    <= wr_data[TW-1:0];
        REG_GYRO_TH:     cfg.gyro_th     <= wr_data[TW-1:0];
        default: ;
      endcase
    end
  end

  assign gyro_raw  = {gyro_in_z, gyro_in_y, gyro_in_x};
  assign accel_raw = {accel_in_z, accel_in_y, accel_in_x};

  gbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .gyro_raw  (gyro_raw),
    .accel_raw (accel_raw),
    .dn_valid  (mid_valid),
    .dn_ready  (mid_ready),
    .dn_beat   (mid_beat)
  );

  gbt_bias u_bias (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .up_valid  (mid_valid),
    .up_ready  (mid_ready),
    .up_beat   (mid_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gyro_res  (gyro_res),
    .accel_res (accel_res),
    .still_res (still_seen),
    .flag_res  (bias_valid)
  );

  assign gyro_out_x  = gyro_res[0];
  assign gyro_out_y  = gyro_res[1];
  assign gyro_out_z  = gyro_res[2];
  assign accel_out_x = accel_res[0];
  assign accel_out_y = accel_res[1];
  assign accel_out_z = accel_res[2];

`ifndef ASSERT_OFF
  // back pressure only ever comes from a stalled result beat
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // once a delivered beat carries the valid flag, later beats keep it
  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && bias_valid) |=> (!out_valid || bias_valid))
    else $error("bias valid flag dropped");
`endif

endmodule

// File: hdl/gbt_remap.sv
// signed axis permutation of one triple, saturating on negation
// depends on gbt_pkg
module gbt_remap (
  input  logic [gbt_pkg::OW-1:0] sel,
  input  gbt_pkg::vec3_t         src,
  output gbt_pkg::vec3_t         dst
);
  import gbt_pkg::*;

  axis_codes_t codes;

  always_comb begin
    codes = orient_map(sel);
    for (int k = 0; k < 3; k++) begin
      if (codes[k][2]) dst[k] = neg_sat(src[codes[k][1:0]]);
      else dst[k] = src[codes[k][1:0]];
    end
  end

endmodule

// File: hdl/gbt_front.sv
// input register, remap with squares and alpha products, still decision
// depends on gbt_pkg and gbt_remap
module gbt_front (
  input  logic                 clk,
  input  logic                 rst,
  input  gbt_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gbt_pkg::vec3_t       gyro_raw,
  input  gbt_pkg::vec3_t       accel_raw,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output gbt_pkg::stage_t      dn_beat
);
  import gbt_pkg::*;

  logic a_valid, b_valid, c_valid;
  logic a_open, b_open, c_open;
  logic a_load, b_load, c_load;

  vec3_t a_gyro, a_accel;
  vec3_t gyro_map, accel_map;
  vec3_t prev_accel;

  vec3_t b_gyro, b_accel;
  logic [2:0][DSQ_W-1:0] b_dsq;
  logic [2:0][GSQ_W-1:0] b_gsq;
  prod3_t b_lp, b_tp;

  stage_t c_beat;

  logic signed [DW:0]      dif    [3];
  logic signed [2*DW+1:0]  dif_sq [3];
  logic signed [2*DW-1:0]  g_sq   [3];
  logic signed [AW+DW:0]   lprod  [3];
  logic signed [AW+DW:0]   tprod  [3];

  logic [ASUM_W-1:0] accel_sum;
  logic [GSUM_W-1:0] gyro_sum;
  logic              still_now;

  assign c_open = !c_valid || dn_ready;
  assign b_open = !b_valid || c_open;
  assign a_open = !a_valid || b_open;
  assign a_load = in_valid && a_open;
  assign b_load = a_valid && b_open;
  assign c_load = b_valid && c_open;
  assign in_stall = !a_open;

  gbt_remap u_gyro_map (
    .sel (cfg.orient),
    .src (a_gyro),
    .dst (gyro_map)
  );

  gbt_remap u_accel_map (
    .sel (cfg.orient),
    .src (a_accel),
    .dst (accel_map)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k] = $signed({prev_accel[k][DW-1], prev_accel[k]})
             - $signed({accel_map[k][DW-1], accel_map[k]});
      dif_sq[k] = dif[k] * dif[k];
      g_sq[k]   = $signed(gyro_map[k]) * $signed(gyro_map[k]);
      lprod[k]  = $signed({1'b0, cfg.learn_alpha}) * $signed(gyro_map[k]);
      tprod[k]  = $signed({1'b0, cfg.track_alpha}) * $signed(gyro_map[k]);
    end
  end

  always_comb begin
    accel_sum = ASUM_W'(b_dsq[0]) + ASUM_W'(b_dsq[1]) + ASUM_W'(b_dsq[2]);
    gyro_sum  = GSUM_W'(b_gsq[0]) + GSUM_W'(b_gsq[1]) + GSUM_W'(b_gsq[2]);
    // strict compare, so a zero threshold never sees still
    still_now = (accel_sum < ASUM_W'(cfg.accel_th)) && (gyro_sum < GSUM_W'(cfg.gyro_th));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      prev_accel <= '0;
    end else begin
      if (a_open) a_valid <= in_valid;
      if (b_open) b_valid <= a_valid;
      if (c_open) c_valid <= b_valid;
      // the first beat after reset compares against zero
      if (b_load) prev_accel <= accel_map;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_gyro  <= gyro_raw;
      a_accel <= accel_raw;
    end
    if (b_load) begin
      b_gyro  <= gyro_map;
      b_accel <= accel_map;
      for (int k = 0; k < 3; k++) begin
        b_dsq[k] <= dif_sq[k][DSQ_W-1:0];
        b_gsq[k] <= g_sq[k][GSQ_W-1:0];
        b_lp[k]  <= lprod[k][PW-1:0];
        b_tp[k]  <= tprod[k][PW-1:0];
      end
    end
    if (c_load) begin
      c_beat.still      <= still_now;
      c_beat.gyro       <= b_gyro;
      c_beat.accel      <= b_accel;
      c_beat.learn_prod <= b_lp;
      c_beat.track_prod <= b_tp;
    end
  end

  assign dn_valid = c_valid;
  assign dn_beat  = c_beat;

endmodule

// File: hdl/gbt_bias.sv
// bias recurrence, still counter and valid flag, then bias removal and result register
// depends on gbt_pkg
module gbt_bias (
  input  logic             clk,
  input  logic             rst,
  input  gbt_pkg::cfg_t    cfg,
  input  logic             up_valid,
  output logic             up_ready,
  input  gbt_pkg::stage_t  up_beat,
  output logic             out_valid,
  input  logic             out_stall,
  output gbt_pkg::vec3_t   gyro_res,
  output gbt_pkg::vec3_t   accel_res,
  output logic             still_res,
  output logic             flag_res
);
  import gbt_pkg::*;

  localparam int HW = BW / 2;       // bias split for the partial products
  localparam int FW = AW + BW;      // low bits of alpha times bias difference

  logic [2:0][BW-1:0] bias;
  logic [CW-1:0]      still_count;
  logic               valid_flag;

  logic  d_valid;
  vec3_t d_gyro, d_accel;
  logic  d_still;

  logic d_open, e_open, d_load, e_load;

  logic          learning;
  logic [AW-1:0] alpha;
  logic [CW-1:0] cnt_inc;

  logic [PW-1:0]            prod_g  [3];
  logic signed [AW+HW:0]    hi_prod [3];
  logic [AW+HW-1:0]         lo_prod [3];
  logic [FW-1:0]            full    [3];

  logic [BW:0]   res_diff [3];
  vec3_t         gyro_fix;

  assign e_open   = !out_valid || !out_stall;
  assign d_open   = !d_valid || e_open;
  assign d_load   = up_valid && d_open;
  assign e_load   = d_valid && e_open;
  assign up_ready = d_open;

  // alpha*(g*2^16 - bias) kept mod 2^64; bits above the shift give the bias step
  always_comb begin
    learning = still_count < cfg.learn_limit;
    alpha    = learning ? cfg.learn_alpha : cfg.track_alpha;
    cnt_inc  = still_count + 1'b1;
    for (int k = 0; k < 3; k++) begin
      prod_g[k]  = learning ? up_beat.learn_prod[k] : up_beat.track_prod[k];
      hi_prod[k] = $signed({1'b0, alpha}) * $signed(bias[k][BW-1:HW]);
      lo_prod[k] = alpha * bias[k][HW-1:0];
      full[k]    = {prod_g[k], {GFRAC{1'b0}}}
                 - {hi_prod[k][FW-HW-1:0], {HW{1'b0}}}
                 - {{(FW-AW-HW){1'b0}}, lo_prod[k]};
    end
  end

  // bias removal reads the bias as it stands after this beat's update
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res_diff[k] = {d_gyro[k][DW-1], d_gyro[k], {GFRAC{1'b0}}}
                  - {bias[k][BW-1], bias[k]};
      gyro_fix[k] = sat_one(res_diff[k][BW:GFRAC]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias        <= '0;
      still_count <= '0;
      valid_flag  <= 1'b0;
      d_valid     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (d_open) d_valid <= up_valid;
      if (e_open) out_valid <= d_valid;
      if (d_load && up_beat.still) begin
        for (int k = 0; k < 3; k++) begin
          bias[k] <= bias[k] + full[k][FW-1:FW-BW];
        end
        if (learning) begin
          still_count <= cnt_inc;
          if (cnt_inc == cfg.learn_limit) valid_flag <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_load) begin
      d_gyro  <= up_beat.gyro;
      d_accel <= up_beat.accel;
      d_still <= up_beat.still;
    end
    if (e_load) begin
      gyro_res  <= gyro_fix;
      accel_res <= d_accel;
      still_res <= d_still;
      flag_res  <= valid_flag;
    end
  end

endmodule
